// ----- hw/rtl/bvmx_pkg.sv -----
// Shared opcodes, decoded-instruction type and result codes for the bytecode execute unit.
package bvmx_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 64;

    localparam logic [7:0] OP_HALT  = 8'h00;
    localparam logic [7:0] OP_LOAD  = 8'h10;
    localparam logic [7:0] OP_STORE = 8'h20;
    localparam logic [7:0] OP_MOVE  = 8'h30;
    localparam logic [7:0] OP_PUTI  = 8'h40;
    localparam logic [7:0] OP_ADD   = 8'h50;
    localparam logic [7:0] OP_SUB   = 8'h60;
    localparam logic [7:0] OP_GT    = 8'h70;
    localparam logic [7:0] OP_GE    = 8'h80;
    localparam logic [7:0] OP_EQ    = 8'h90;
    localparam logic [7:0] OP_ITE   = 8'ha0;
    localparam logic [7:0] OP_JUMP  = 8'hb0;
    localparam logic [7:0] OP_PUTS  = 8'hc0;
    localparam logic [7:0] OP_GETS  = 8'hd0;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_HALT  = 3'd1;
    localparam logic [2:0] STAT_HEAP  = 3'd2;
    localparam logic [2:0] STAT_BADOP = 3'd3;
    localparam logic [2:0] STAT_IO    = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        K_HALT, K_LOAD, K_STORE, K_MOVE, K_PUTI, K_ADD, K_SUB,
        K_GT, K_GE, K_EQ, K_ITE, K_JUMP, K_IO, K_BAD
    } kind_t;

    // One classified instruction as it travels from the front end to the back end.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] ra_idx;
        logic [7:0] rb_idx;
    } dec_t;

endpackage

// ----- hw/rtl/bvmx_front.sv -----
// Front end: accepts instruction words and classifies them into decoded entries.
module bvmx_front
    import bvmx_pkg::*;
(
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,   // instr_word[31:0]
    input  logic            hold,
    input  logic            q_full,
    output logic            push,
    output dec_t            item
);

    logic [7:0] opcode;

    assign opcode   = s_tdata[7:0];
    assign s_tready = !q_full && !hold;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        item.b1     = s_tdata[15:8];
        item.b2     = s_tdata[23:16];
        item.b3     = s_tdata[31:24];
        item.ra_idx = s_tdata[23:16];
        item.rb_idx = s_tdata[31:24];
        item.kind   = K_BAD;
        unique case (opcode) inside
            OP_HALT:  item.kind = K_HALT;
            OP_LOAD:  item.kind = K_LOAD;
            OP_STORE: begin
                // The address comes from B1 and the stored byte from B2.
                item.kind   = K_STORE;
                item.ra_idx = s_tdata[15:8];
                item.rb_idx = s_tdata[23:16];
            end
            OP_MOVE:  item.kind = K_MOVE;
            OP_PUTI:  item.kind = K_PUTI;
            OP_ADD:   item.kind = K_ADD;
            OP_SUB:   item.kind = K_SUB;
            OP_GT:    item.kind = K_GT;
            OP_GE:    item.kind = K_GE;
            OP_EQ:    item.kind = K_EQ;
            OP_ITE: begin
                item.kind   = K_ITE;
                item.ra_idx = s_tdata[15:8];
            end
            OP_JUMP:  item.kind = K_JUMP;
            OP_PUTS, OP_GETS: item.kind = K_IO;
            default:  item.kind = K_BAD;
        endcase
    end

endmodule

// ----- hw/rtl/bvmx_queue.sv -----
// Short first-in first-out queue of decoded instructions between front and back ends.
module bvmx_queue
    import bvmx_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  dec_t push_item,
    output logic full,
    input  logic pop,
    output logic valid,
    output dec_t head
);

    dec_t                entries_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entries_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/bvmx_back.sv -----
// Back end: register file, heap, program counter and the result register.
module bvmx_back
    import bvmx_pkg::*;
#(
    parameter int REG_COUNT  = 256,
    parameter int HEAP_BYTES = 8192
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  dec_t             q_head,
    output logic             pop,
    output logic             clr_busy,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[2:0], next_pc[18:3], reg_written[19], dest_index[27:20], dest_value[59:28]
    output logic [OUT_W-1:0] m_tdata
);

    localparam int REG_AW = $clog2(REG_COUNT);
    localparam int HEAP_AW = $clog2(HEAP_BYTES);
    localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);
    localparam logic [31:0] HEAP_LIMIT = 32'(HEAP_BYTES);
    localparam logic [HEAP_AW-1:0] HEAP_LAST = HEAP_AW'(HEAP_BYTES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [31:0]         rf_mem [REG_COUNT];
    logic [7:0]          heap_mem [HEAP_BYTES];
    logic [REG_COUNT-1:0] rf_valid_reg;

    logic [1:0]          state_reg, state_next;
    dec_t                cur_reg;
    logic [31:0]         rda_reg, rdb_reg;
    logic                rda_ok_reg, rdb_ok_reg;
    logic [7:0]          heap_rdata_reg;
    logic [15:0]         pc_reg;
    logic                stopped_reg;
    logic                clr_busy_reg;
    logic [HEAP_AW-1:0]  clr_cnt_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [31:0]         opa, opb;
    logic                heap_ok;
    logic [2:0]          status;
    logic [15:0]         npc;
    logic                wr, wr_ok, store_en, stop, need_load;
    logic [31:0]         val;
    logic [7:0]          dest_idx;
    logic                out_free, commit, load_go;
    logic                heap_we;
    logic [HEAP_AW-1:0]  heap_wa;
    logic [7:0]          heap_wd;

    assign clr_busy = clr_busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pop      = (state_reg == S_IDLE) && q_valid && !clr_busy_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Entries never written read as zero, as do indices beyond the register file.
    assign opa     = rda_ok_reg ? rda_reg : '0;
    assign opb     = rdb_ok_reg ? rdb_reg : '0;
    assign heap_ok = (opa < HEAP_LIMIT);

    always_comb begin
        status    = STAT_OK;
        npc       = pc_reg + 16'd1;
        wr        = 1'b0;
        val       = '0;
        store_en  = 1'b0;
        stop      = 1'b0;
        need_load = 1'b0;
        if (stopped_reg) begin
            status = STAT_HALT;
            npc    = pc_reg;
        end else begin
            unique case (cur_reg.kind)
                K_HALT:  status = STAT_HALT;
                K_LOAD: begin
                    if (!heap_ok) begin
                        status = STAT_HEAP;
                    end else begin
                        wr        = 1'b1;
                        val       = {24'd0, heap_rdata_reg};
                        need_load = 1'b1;
                    end
                end
                K_STORE: begin
                    if (!heap_ok) begin
                        status = STAT_HEAP;
                    end else begin
                        store_en = 1'b1;
                    end
                end
                K_MOVE: begin wr = 1'b1; val = opa; end
                K_PUTI: begin wr = 1'b1; val = {24'd0, cur_reg.b2}; end
                K_ADD:  begin wr = 1'b1; val = opa + opb; end
                K_SUB:  begin wr = 1'b1; val = opa - opb; end
                K_GT:   begin wr = 1'b1; val = {31'd0, opa > opb}; end
                K_GE:   begin wr = 1'b1; val = {31'd0, opa >= opb}; end
                K_EQ:   begin wr = 1'b1; val = {31'd0, opa == opb}; end
                K_ITE:  npc = (opa != '0) ? {8'd0, cur_reg.b2} : {8'd0, cur_reg.b3};
                K_JUMP: npc = {8'd0, cur_reg.b1};
                K_IO:   status = STAT_IO;
                K_BAD:  status = STAT_BADOP;
                default: status = STAT_BADOP;
            endcase
            if (status != STAT_OK) begin
                stop     = 1'b1;
                npc      = pc_reg;
                wr       = 1'b0;
                store_en = 1'b0;
            end
        end
        wr_ok    = wr && ({1'b0, cur_reg.b1} < REG_LIMIT);
        dest_idx = wr_ok ? cur_reg.b1 : '0;
        if (!wr_ok) begin
            val = '0;
        end
    end

    assign load_go = (state_reg == S_EXEC) && need_load;
    assign commit  = out_free &&
                     (((state_reg == S_EXEC) && !need_load) || (state_reg == S_LOAD));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (pop) state_next = S_EXEC;
            S_EXEC: begin
                if (load_go) begin
                    state_next = S_LOAD;
                end else if (commit) begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:  if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // The clearing pass owns the heap write port until it has swept every byte.
    assign heap_we = clr_busy_reg || (commit && store_en);
    assign heap_wa = clr_busy_reg ? clr_cnt_reg : opa[HEAP_AW-1:0];
    assign heap_wd = clr_busy_reg ? 8'd0 : opb[7:0];

    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (load_go) begin
            heap_rdata_reg <= heap_mem[opa[HEAP_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && wr_ok) begin
            rf_mem[cur_reg.b1[REG_AW-1:0]] <= val;
        end
        if (pop) begin
            rda_reg <= rf_mem[q_head.ra_idx[REG_AW-1:0]];
            rdb_reg <= rf_mem[q_head.rb_idx[REG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg    <= q_head;
            rda_ok_reg <= ({1'b0, q_head.ra_idx} < REG_LIMIT) &&
                          rf_valid_reg[q_head.ra_idx[REG_AW-1:0]];
            rdb_ok_reg <= ({1'b0, q_head.rb_idx} < REG_LIMIT) &&
                          rf_valid_reg[q_head.rb_idx[REG_AW-1:0]];
        end
        if (commit) begin
            m_tdata_reg <= {(OUT_W-60)'(0), val, dest_idx, wr_ok, npc, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
            rf_valid_reg <= '0;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == HEAP_LAST) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (commit) begin
                pc_reg      <= npc;
                stopped_reg <= stopped_reg || stop;
                if (wr_ok) begin
                    rf_valid_reg[cur_reg.b1[REG_AW-1:0]] <= 1'b1;
                end
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/bytecode_vm_execute_unit_top.sv -----
// Top level of the bytecode execute unit: front end, instruction queue and back end.
//
// Each input word on s_* is one 32-bit instruction; each instruction gives exactly one result
// word on m_*, in order, carrying status, next pc and the register write it made, if any.
// The front end classifies the opcode and places the instruction in a four-entry queue, so
// s_tready stays high while the back end is busy or the receiver stalls, until the queue fills.
// The back end takes one instruction at a time: it reads two register file ports as it pops
// the queue, then executes and commits; a heap load adds a state for the heap read.
// It pops the next instruction only after the current one has committed its result.
// All state is committed in the same cycle the result enters the output register, so a stall
// on m_tready simply holds the back end and then backs up into the queue.
// After reset the heap is swept to zero, one byte a cycle, until every byte is clear; s_tready
// is low for that time. The register file reads as zero until each entry is written.
// After halt or any fault the unit stays stopped and answers every word with status halted
// until the next reset.
module bytecode_vm_execute_unit_top
    import bvmx_pkg::*;
#(
    parameter int REG_COUNT  = 256,
    parameter int HEAP_BYTES = 8192
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // instr_word[31:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[2:0], next_pc[18:3], reg_written[19], dest_index[27:20], dest_value[59:28]
    output logic [OUT_W-1:0] m_tdata
);

    logic push, q_full, q_valid, pop, clr_busy;
    dec_t push_item, q_head;

    bvmx_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .hold     (clr_busy),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    bvmx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    bvmx_back #(
        .REG_COUNT  (REG_COUNT),
        .HEAP_BYTES (HEAP_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .clr_busy (clr_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- verif/bytecode_vm_execute_unit_checker.sv -----
// Checker for the bytecode execute unit: mirrors its state and compares each result word.
`timescale 1ns / 100ps
module bytecode_vm_execute_unit_checker
    import bvmx_pkg::*;
#(
    parameter int REG_COUNT  = 256,
    parameter int HEAP_BYTES = 8192
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // instr_word[31:0]
    input  logic             m_tvalid,
    input  logic             m_tready,
    // status[2:0], next_pc[18:3], reg_written[19], dest_index[27:20], dest_value[59:28]
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               checked
);

    // Declared from the top field down so that it lines up with the result word.
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  dest;
        logic        wrote;
        logic [15:0] next_pc;
        logic [2:0]  status;
    } outcome_t;

    outcome_t    awaited[$];
    logic [31:0] regs[REG_COUNT];
    logic [7:0]  heap[HEAP_BYTES];
    logic [15:0] pc;
    logic        halted;

    function automatic logic [31:0] read_reg(logic [7:0] idx);
        if (idx >= REG_COUNT) return '0;
        return regs[idx];
    endfunction

    // Executes one instruction against the mirrored state and returns its result word.
    function automatic outcome_t retire_instr(logic [31:0] word);
        logic [7:0]  op, b1, b2, b3;
        logic [31:0] lhs, rhs, addr;
        outcome_t    o;
        op = word[7:0];
        b1 = word[15:8];
        b2 = word[23:16];
        b3 = word[31:24];
        o  = '0;
        if (halted) begin
            o.status  = STAT_HALT;
            o.next_pc = pc;
            return o;
        end
        o.status  = STAT_OK;
        o.next_pc = pc + 16'd1;
        lhs = read_reg(b2);
        rhs = read_reg(b3);
        case (op)
            OP_HALT: o.status = STAT_HALT;
            OP_LOAD: begin
                if (lhs >= HEAP_BYTES) begin
                    o.status = STAT_HEAP;
                end else begin
                    o.wrote = 1'b1;
                    o.value = {24'd0, heap[lhs]};
                end
            end
            OP_STORE: begin
                addr = read_reg(b1);
                if (addr >= HEAP_BYTES) o.status = STAT_HEAP;
                else heap[addr] = lhs[7:0];
            end
            OP_MOVE: begin
                o.wrote = 1'b1;
                o.value = lhs;
            end
            OP_PUTI: begin
                o.wrote = 1'b1;
                o.value = {24'd0, b2};
            end
            OP_ADD: begin
                o.wrote = 1'b1;
                o.value = lhs + rhs;
            end
            OP_SUB: begin
                o.wrote = 1'b1;
                o.value = lhs - rhs;
            end
            OP_GT: begin
                o.wrote = 1'b1;
                o.value = {31'd0, lhs > rhs};
            end
            OP_GE: begin
                o.wrote = 1'b1;
                o.value = {31'd0, lhs >= rhs};
            end
            OP_EQ: begin
                o.wrote = 1'b1;
                o.value = {31'd0, lhs == rhs};
            end
            OP_ITE:  o.next_pc = (read_reg(b1) != '0) ? {8'd0, b2} : {8'd0, b3};
            OP_JUMP: o.next_pc = {8'd0, b1};
            OP_PUTS, OP_GETS: o.status = STAT_IO;
            default: o.status = STAT_BADOP;
        endcase
        if (o.status != STAT_OK) begin
            // Every way of stopping holds the pc and drops the register write.
            halted    = 1'b1;
            o.next_pc = pc;
            o.wrote   = 1'b0;
            o.value   = '0;
        end else begin
            pc = o.next_pc;
        end
        if (o.wrote && b1 < REG_COUNT) begin
            regs[b1] = o.value;
            o.dest   = b1;
        end else begin
            o.wrote = 1'b0;
            o.value = '0;
            o.dest  = '0;
        end
        return o;
    endfunction

    always @(posedge aclk) begin : monitor
        outcome_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
            for (int i = 0; i < HEAP_BYTES; i++) heap[i] = '0;
            pc     = '0;
            halted = 1'b0;
            awaited.delete();
        end else begin
            if (s_tvalid && s_tready) awaited.push_back(retire_instr(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[59:0];
                if (awaited.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: result word %h arrived with nothing outstanding",
                                 $time, m_tdata);
                end else begin
                    want = awaited.pop_front();
                    checked++;
                    if (got.status !== want.status || got.next_pc !== want.next_pc ||
                        got.wrote !== want.wrote || got.dest !== want.dest ||
                        got.value !== want.value) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t: result %0d expected status %0d pc %h wr %b ",
                                     $time, checked, want.status, want.next_pc, want.wrote,
                                     "dest %h value %h, got status %0d pc %h wr %b ",
                                     want.dest, want.value, got.status, got.next_pc,
                                     got.wrote, "dest %h value %h", got.dest, got.value);
                    end
                end
            end
        end
        pending <= awaited.size();
    end

endmodule

// ----- verif/bytecode_vm_execute_unit_top_tb.sv -----
// Testbench top for the bytecode execute unit: clock, reset, instruction stream and verdict.
`timescale 1ns / 100ps
module bytecode_vm_execute_unit_top_tb;
    import bvmx_pkg::*;

    localparam int REG_COUNT       = 256;
    localparam int HEAP_BYTES      = 8192;
    localparam int CLK_PERIOD      = 12;
    localparam int RANDOM_ITEMS    = 1125;
    localparam int DRAIN_AT        = 600;
    localparam int HOLD_OFF_AT     = 250;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 30000;
    localparam int IGNORED_WORDS   = 24;

    // Sixteen registers from here up hold heap addresses and are written by address set-up only.
    localparam logic [7:0] ADDR_REG = 8'h80;
    localparam logic [7:0] TMP_REG  = 8'h7f;

    typedef enum int {
        STOP_HALT, STOP_LOAD_FAULT, STOP_STORE_FAULT, STOP_BAD_OP, STOP_PUTS, STOP_GETS
    } stop_e;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // instr_word[31:0]
    logic             m_tvalid;
    logic             m_tready;
    // status[2:0], next_pc[18:3], reg_written[19], dest_index[27:20], dest_value[59:28]
    logic [OUT_W-1:0] m_tdata;

    int    fail_count;
    int    pending;
    int    checked;
    int    sent;
    int    loads;
    int    stores;
    int    builds;
    string stop_cause;

    bytecode_vm_execute_unit_top #(
        .REG_COUNT (REG_COUNT),
        .HEAP_BYTES(HEAP_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    bytecode_vm_execute_unit_checker #(
        .REG_COUNT (REG_COUNT),
        .HEAP_BYTES(HEAP_BYTES)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending),
        .checked   (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [31:0] instr(logic [7:0] op, logic [7:0] b1, logic [7:0] b2,
                                          logic [7:0] b3);
        return {b3, b2, b1, op};
    endfunction

    // A small pool of registers makes results feed into later instructions.
    function automatic logic [7:0] pick_src();
        logic [7:0] r;
        if ($urandom_range(0, 3) != 0) r = 8'($urandom_range(0, 15));
        else r = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic logic [7:0] pick_dest();
        logic [7:0] r;
        r = pick_src();
        if (r[7:4] == ADDR_REG[7:4]) r[7] = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] pick_addr_reg();
        logic [7:0] r;
        r = 8'($urandom_range(0, 15));
        return ADDR_REG | r;
    endfunction

    // Offers one word after a random gap and returns at the edge where it is taken.
    task automatic issue(input logic [31:0] word);
        int gap;
        gap = (sent % 64 < 16) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Builds a 16-bit address: high byte, eight doublings, then the low byte added in.
    task automatic set_address(input logic [7:0] areg, input logic [15:0] value);
        issue(instr(OP_PUTI, areg, value[15:8], 8'h00));
        repeat (8) issue(instr(OP_ADD, areg, areg, areg));
        issue(instr(OP_PUTI, TMP_REG, value[7:0], 8'h00));
        issue(instr(OP_ADD, areg, areg, TMP_REG));
    endtask

    initial begin : result_sink
        int wait_cycles;
        int taken;
        m_tready <= 1'b0;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            wait_cycles = (taken % 64 >= 40) ? 0 : $urandom_range(0, 9);
            // One long hold-off lets the queue fill and push back on the input.
            if (taken == HOLD_OFF_AT) wait_cycles = HOLD_OFF_CYCLES;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("bytecode_vm_execute_unit_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        int          pick;
        int          target;
        bit          drained;
        logic [7:0]  a, b, c, d, e;
        logic [7:0]  areg;
        logic [7:0]  bad_op;
        logic [15:0] addr;
        stop_e       stop_kind;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        drained  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, wrapping arithmetic, unsigned compares, heap and branches.
        issue(instr(OP_PUTI, 8'h00, 8'hff, 8'h00));
        issue(instr(OP_PUTI, 8'hff, 8'h80, 8'hff));
        issue(instr(OP_ADD, 8'h01, 8'h00, 8'hff));
        issue(instr(OP_PUTI, 8'h03, 8'h01, 8'h00));
        issue(instr(OP_SUB, 8'h02, 8'h04, 8'h03));
        issue(instr(OP_ADD, 8'h05, 8'h02, 8'h02));
        issue(instr(OP_ADD, 8'h06, 8'h02, 8'h03));
        issue(instr(OP_GT, 8'h07, 8'h02, 8'h03));
        issue(instr(OP_GT, 8'h08, 8'h03, 8'h02));
        issue(instr(OP_GE, 8'h09, 8'h03, 8'h03));
        issue(instr(OP_GE, 8'h0a, 8'h03, 8'h02));
        issue(instr(OP_EQ, 8'h0b, 8'h06, 8'h04));
        issue(instr(OP_EQ, 8'h0c, 8'h02, 8'h05));
        issue(instr(OP_MOVE, 8'hfe, 8'h02, 8'h00));
        issue(instr(OP_PUTI, ADDR_REG, 8'h00, 8'h00));
        issue(instr(OP_STORE, ADDR_REG, 8'h02, 8'h00));
        issue(instr(OP_LOAD, 8'h0d, ADDR_REG, 8'h00));
        issue(instr(OP_PUTI, ADDR_REG | 8'h0f, 8'hff, 8'h00));
        issue(instr(OP_LOAD, 8'h0e, ADDR_REG | 8'h0f, 8'h00));
        issue(instr(OP_ITE, 8'h02, 8'hab, 8'h12));
        issue(instr(OP_ITE, 8'h04, 8'hff, 8'h00));
        issue(instr(OP_JUMP, 8'hff, 8'h00, 8'h00));
        issue(instr(OP_JUMP, 8'h00, 8'hff, 8'hff));
        loads  = 2;
        stores = 1;

        // Random programme that never leaves the heap, so the unit keeps running throughout.
        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            if (!drained && sent >= DRAIN_AT) begin
                // Stop offering until every outstanding word has come back.
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            pick = $urandom_range(0, 99);
            a = pick_dest();
            b = pick_src();
            c = pick_src();
            d = 8'($urandom_range(0, 255));
            e = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) c = b;
            if (pick < 14) begin
                issue(instr(OP_PUTI, a, d, e));
            end else if (pick < 20) begin
                issue(instr(OP_MOVE, a, b, e));
            end else if (pick < 30) begin
                issue(instr(OP_ADD, a, b, c));
            end else if (pick < 38) begin
                issue(instr(OP_SUB, a, b, c));
            end else if (pick < 44) begin
                issue(instr(OP_GT, a, b, c));
            end else if (pick < 50) begin
                issue(instr(OP_GE, a, b, c));
            end else if (pick < 56) begin
                issue(instr(OP_EQ, a, b, c));
            end else if (pick < 66) begin
                issue(instr(OP_LOAD, a, pick_addr_reg(), e));
                loads++;
            end else if (pick < 78) begin
                issue(instr(OP_STORE, pick_addr_reg(), b, e));
                stores++;
            end else if (pick < 84) begin
                issue(instr(OP_ITE, b, d, e));
            end else if (pick < 88) begin
                issue(instr(OP_JUMP, d, e, c));
            end else if (pick < 97) begin
                issue(instr(OP_PUTI, pick_addr_reg(), d, e));
            end else begin
                addr = 16'(($urandom_range(0, 3) == 0) ? HEAP_BYTES - 1
                                                       : $urandom_range(0, HEAP_BYTES - 1));
                set_address(pick_addr_reg(), addr);
                builds++;
            end
        end

        // End the programme with one way of stopping, then check that the unit stays stopped.
        stop_kind = stop_e'($urandom_range(0, 5));
        areg = ADDR_REG;
        if (stop_kind == STOP_LOAD_FAULT || stop_kind == STOP_STORE_FAULT) begin
            if ($urandom_range(0, 1) == 1) begin
                addr = 16'(HEAP_BYTES);
                set_address(areg, addr);
            end else begin
                issue(instr(OP_PUTI, areg, 8'h00, 8'h00));
                issue(instr(OP_PUTI, TMP_REG, 8'h01, 8'h00));
                issue(instr(OP_SUB, areg, areg, TMP_REG));
            end
        end
        d = 8'($urandom_range(0, 255));
        e = 8'($urandom_range(0, 255));
        case (stop_kind)
            STOP_HALT: begin
                issue(instr(OP_HALT, d, e, d));
                stop_cause = "a halt";
            end
            STOP_LOAD_FAULT: begin
                issue(instr(OP_LOAD, pick_dest(), areg, e));
                stop_cause = "a load outside the heap";
            end
            STOP_STORE_FAULT: begin
                issue(instr(OP_STORE, areg, pick_src(), e));
                stop_cause = "a store outside the heap";
            end
            STOP_BAD_OP: begin
                do bad_op = 8'($urandom_range(0, 255));
                while (bad_op[3:0] == 4'h0 && bad_op <= OP_GETS);
                issue(instr(bad_op, d, e, d));
                stop_cause = "an unknown opcode";
            end
            STOP_PUTS: begin
                issue(instr(OP_PUTS, d, e, d));
                stop_cause = "a string output request";
            end
            default: begin
                issue(instr(OP_GETS, d, e, d));
                stop_cause = "a string input request";
            end
        endcase
        repeat (IGNORED_WORDS) issue($urandom());
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Ran %0d instructions (%0d loads, %0d stores, %0d address builds); %0d results.",
                 sent, loads, stores, builds, checked);
        $display("The programme ended with %s; %0d further words went to the stopped unit.",
                 stop_cause, IGNORED_WORDS);
        if (fail_count == 0) begin
            $display("bytecode_vm_execute_unit_top regression: pass");
        end else begin
            $display("bytecode_vm_execute_unit_top regression: fail");
        end
        $finish;
    end

endmodule
